// ----- design/mlptw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker package
// Shared constants, mode codes and the request and result transfer types.
// ----------------------------------------------------------------------------
package mlptw_pkg;

  // Default geometry
  localparam int OFFSET_BITS_DEF = 12;
  localparam int LEVEL_COUNT_DEF = 4;
  localparam int PHYS_PAGES_DEF  = 32;

  // Fixed field widths and table entry size
  localparam int VA_W           = 48;
  localparam int PA_W           = 17;
  localparam int PTE_BYTES_LOG2 = 3;

  // Request modes
  localparam logic MODE_TRANSLATE = 1'b0;
  localparam logic MODE_ALLOCATE  = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [VA_W-1:0] virtual_address;
  } request_t;

  typedef struct packed {
    logic [PA_W-1:0] mapped_address;
    logic            fault;
    logic            out_of_memory;
  } result_t;

endpackage

// ----- design/multilevel_page_table_walker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel page table walker
// Walks LEVEL_COUNT levels of page tables kept in an internal entry memory,
// translating a virtual address or allocating the mapping from a bump
// page allocator.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request steps
// through ST_ROOT, which resolves the root table, and then ST_WALK once per
// level, a pace set by the single read port of the entry memory with its
// registered read; a write of a fresh entry shares its level's cycle. Busy
// stays high until the walk ends, so no new request is taken before then.
// A request that faults or runs out of pages finishes early.
// The result appears for exactly one cycle with done high, in the cycle busy
// drops; the receiver cannot stall it and must take it then. After reset the
// block sweeps the entry memory to zero, one entry a cycle, through all
// PHYS_PAGES * 2^(OFFSET_BITS-3) entries (16384 at the defaults) with busy
// high. Pages are never returned; once PHYS_PAGES pages are handed out, an
// allocation that needs a fresh page reports out_of_memory.
// ----------------------------------------------------------------------------
module multilevel_page_table_walker #(
  parameter int OFFSET_BITS = mlptw_pkg::OFFSET_BITS_DEF,
  parameter int LEVEL_COUNT = mlptw_pkg::LEVEL_COUNT_DEF,
  parameter int PHYS_PAGES  = mlptw_pkg::PHYS_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mlptw_pkg::request_t request,
  output logic                done,
  output mlptw_pkg::result_t  result
);

  localparam int IDX_BITS = OFFSET_BITS - mlptw_pkg::PTE_BYTES_LOG2;
  localparam int PAGE_W   = $clog2(PHYS_PAGES);
  localparam int NFP_W    = $clog2(PHYS_PAGES + 1);
  localparam int ENTRY_W  = PAGE_W + 1;
  localparam int ADDR_W   = PAGE_W + IDX_BITS;
  localparam int DEPTH    = PHYS_PAGES * (1 << IDX_BITS);
  localparam int LVL_W    = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int PA_W     = mlptw_pkg::PA_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_ROOT  = 4'b0100,
    ST_WALK  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic                      alloc, alloc_next;
  logic [mlptw_pkg::VA_W-1:0] va, va_next;
  logic [LVL_W-1:0]          lvl, lvl_next;
  logic [ADDR_W-1:0]         slot, slot_next;
  logic [PAGE_W-1:0]         root_page, root_page_next;
  logic                      root_valid, root_valid_next;
  logic [NFP_W-1:0]          next_free_page, next_free_page_next;
  logic [ADDR_W-1:0]         clr_cnt, clr_cnt_next;
  logic                      done_next;
  mlptw_pkg::result_t        result_next;

  // Entry memory and its ports
  logic [ENTRY_W-1:0] pte_store [DEPTH];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [ENTRY_W-1:0] mem_wd;
  logic [ENTRY_W-1:0] rd_data;

  // Per-level index fields of the held address
  logic [IDX_BITS-1:0] lvl_idx [LEVEL_COUNT];
  logic [LVL_W-1:0]    lvl_inc;
  logic                lvl_last;
  logic                pages_out;
  logic [PAGE_W-1:0]   fresh_page;
  logic [PAGE_W-1:0]   walk_page;
  logic [OFFSET_BITS-1:0] offset;

  always_comb begin
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      lvl_idx[l] = IDX_BITS'(va >> (OFFSET_BITS + (LEVEL_COUNT - 1 - l) * IDX_BITS));
    end
  end

  assign lvl_inc    = lvl + LVL_W'(1);
  assign lvl_last   = (lvl == LVL_W'(LEVEL_COUNT - 1));
  assign pages_out  = (next_free_page >= NFP_W'(PHYS_PAGES));
  assign fresh_page = PAGE_W'(next_free_page);
  assign offset     = va[OFFSET_BITS-1:0];
  assign busy       = (state != ST_IDLE);

  // Read every cycle at the next slot; write the clear sweep or a fresh entry
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pte_store[mem_wa] <= mem_wd;
    end
    rd_data <= pte_store[slot_next];
  end

  // Sequence the walk
  always_comb begin
    state_next          = state;
    alloc_next          = alloc;
    va_next             = va;
    lvl_next            = lvl;
    slot_next           = slot;
    root_page_next      = root_page;
    root_valid_next     = root_valid;
    next_free_page_next = next_free_page;
    clr_cnt_next        = clr_cnt;
    done_next           = 1'b0;
    result_next         = result;
    mem_we              = 1'b0;
    mem_wa              = slot;
    mem_wd              = {fresh_page, 1'b1};
    walk_page           = rd_data[ENTRY_W-1:1];

    unique case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_cnt;
        mem_wd       = '0;
        clr_cnt_next = clr_cnt + ADDR_W'(1);
        if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          alloc_next = (request.mode == mlptw_pkg::MODE_ALLOCATE);
          va_next    = request.virtual_address;
          state_next = ST_ROOT;
        end
      end

      ST_ROOT: begin
        lvl_next = '0;
        if (root_valid) begin
          slot_next  = {root_page, lvl_idx[0]};
          state_next = ST_WALK;
        end else if (!alloc) begin
          result_next = '{mapped_address: '0, fault: 1'b1, out_of_memory: 1'b0};
          done_next   = 1'b1;
          state_next  = ST_IDLE;
        end else if (pages_out) begin
          result_next = '{mapped_address: '0, fault: 1'b0, out_of_memory: 1'b1};
          done_next   = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          root_page_next      = fresh_page;
          root_valid_next     = 1'b1;
          next_free_page_next = next_free_page + NFP_W'(1);
          slot_next           = {fresh_page, lvl_idx[0]};
          state_next          = ST_WALK;
        end
      end

      ST_WALK: begin
        if (!rd_data[0] && !alloc) begin
          result_next = '{mapped_address: '0, fault: 1'b1, out_of_memory: 1'b0};
          done_next   = 1'b1;
          state_next  = ST_IDLE;
        end else if (!rd_data[0] && pages_out) begin
          result_next = '{mapped_address: '0, fault: 1'b0, out_of_memory: 1'b1};
          done_next   = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          // Fill an invalid entry with a fresh page
          if (!rd_data[0]) begin
            mem_we              = 1'b1;
            walk_page           = fresh_page;
            next_free_page_next = next_free_page + NFP_W'(1);
          end
          if (lvl_last) begin
            result_next = '{
              mapped_address: PA_W'({walk_page, offset}),
              fault:          1'b0,
              out_of_memory:  1'b0
            };
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            lvl_next  = lvl_inc;
            slot_next = {walk_page, lvl_idx[lvl_inc]};
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      lvl            <= '0;
      root_page      <= '0;
      root_valid     <= 1'b0;
      next_free_page <= '0;
      clr_cnt        <= '0;
      done           <= 1'b0;
    end else begin
      state          <= state_next;
      lvl            <= lvl_next;
      root_page      <= root_page_next;
      root_valid     <= root_valid_next;
      next_free_page <= next_free_page_next;
      clr_cnt        <= clr_cnt_next;
      done           <= done_next;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    alloc  <= alloc_next;
    va     <= va_next;
    slot   <= slot_next;
    result <= result_next;
  end

endmodule

// ----- dv/multilevel_page_table_walker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel page table walker testbench
// Sends translate and allocate requests and keeps its own page table image,
// root pointer and page allocator to work out each result. Every result that
// the walker returns is checked field by field against the oldest one due.
// Covers walks with no root, first allocation, extreme index fields, a long
// random mix over clustered addresses, and allocation until pages run out.
// ----------------------------------------------------------------------------
module multilevel_page_table_walker_tb;

  localparam int OFFSET_BITS = mlptw_pkg::OFFSET_BITS_DEF;
  localparam int LEVEL_COUNT = mlptw_pkg::LEVEL_COUNT_DEF;
  localparam int PHYS_PAGES  = mlptw_pkg::PHYS_PAGES_DEF;
  localparam int VA_W        = mlptw_pkg::VA_W;
  localparam int PA_W        = mlptw_pkg::PA_W;
  localparam int IDX_BITS    = OFFSET_BITS - mlptw_pkg::PTE_BYTES_LOG2;
  localparam int ENTRIES     = 1 << IDX_BITS;
  localparam int DEPTH       = PHYS_PAGES * ENTRIES;
  localparam int ENTRY_W     = $clog2(PHYS_PAGES) + 1;
  localparam int RANDOM_ITEMS = 600;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  mlptw_pkg::request_t request = '0;
  logic                busy;
  logic                done;
  mlptw_pkg::result_t  result;

  // Expected walker state
  logic [ENTRY_W-1:0] table_image [DEPTH];
  int unsigned        root_page;
  logic               root_valid;
  int unsigned        next_free_page;

  mlptw_pkg::result_t expected_results [$];
  int                 fail_count = 0;
  logic               idling_on = 1'b0;

  multilevel_page_table_walker #(
    .OFFSET_BITS(OFFSET_BITS),
    .LEVEL_COUNT(LEVEL_COUNT),
    .PHYS_PAGES (PHYS_PAGES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Index field of one level; a field above the address bits reads as zero
  function automatic int unsigned level_index(input logic [VA_W-1:0] va, input int lvl);
    int unsigned shift;
    shift = OFFSET_BITS + (LEVEL_COUNT - 1 - lvl) * IDX_BITS;
    if (shift >= VA_W) return 0;
    return int'((va >> shift) & (ENTRIES - 1));
  endfunction

  // Walk the table image for one request, updating it as the walker would
  function automatic mlptw_pkg::result_t walk_tables(input logic mode,
                                                     input logic [VA_W-1:0] va);
    mlptw_pkg::result_t res;
    logic               alloc;
    int unsigned        page;
    int unsigned        slot;
    logic [ENTRY_W-1:0] entry;
    res = '0;
    alloc = (mode == mlptw_pkg::MODE_ALLOCATE);
    if (!root_valid) begin
      if (!alloc) begin
        res.fault = 1'b1;
        return res;
      end
      if (next_free_page >= PHYS_PAGES) begin
        res.out_of_memory = 1'b1;
        return res;
      end
      root_page = next_free_page;
      next_free_page++;
      root_valid = 1'b1;
    end
    page = root_page;
    for (int lvl = 0; lvl < LEVEL_COUNT; lvl++) begin
      slot = page * ENTRIES + level_index(va, lvl);
      if (slot >= DEPTH) slot = 0;
      entry = table_image[slot];
      if (entry[0]) begin
        page = 32'(entry[ENTRY_W-1:1]);
      end else if (!alloc) begin
        res.fault = 1'b1;
        return res;
      end else if (next_free_page >= PHYS_PAGES) begin
        res.out_of_memory = 1'b1;
        return res;
      end else begin
        table_image[slot] = ENTRY_W'((next_free_page << 1) | 1);
        page = next_free_page;
        next_free_page++;
      end
    end
    res.mapped_address = PA_W'((page << OFFSET_BITS) + va[OFFSET_BITS-1:0]);
    return res;
  endfunction

  // Address with each level index drawn from a few values, so paths share tables
  function automatic logic [VA_W-1:0] clustered_address();
    logic [VA_W-1:0] va;
    int unsigned     pick;
    va = '0;
    for (int lvl = 0; lvl < LEVEL_COUNT; lvl++) begin
      pick = $urandom_range(0, 3);
      if (pick == 3) pick = ENTRIES - 1;
      va = va | (VA_W'(pick) << (OFFSET_BITS + (LEVEL_COUNT - 1 - lvl) * IDX_BITS));
    end
    va[OFFSET_BITS-1:0] = OFFSET_BITS'($urandom_range(0, (1 << OFFSET_BITS) - 1));
    return va;
  endfunction

  function automatic logic [VA_W-1:0] random_address();
    return VA_W'({$urandom(), $urandom()});
  endfunction

  // Present one request and hold it until the walker takes it
  task automatic send_request(input logic mode, input logic [VA_W-1:0] va);
    mlptw_pkg::request_t req;
    req.mode = mode;
    req.virtual_address = va;
    start <= 1'b1;
    request <= req;
    do @(negedge clk); while (busy);
    @(posedge clk);
    expected_results.push_back(walk_tables(mode, va));
  endtask

  // Drop start for a random burst when idling is enabled
  task automatic maybe_idle();
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic test_translate_without_root();
    send_request(mlptw_pkg::MODE_TRANSLATE, '0);
    send_request(mlptw_pkg::MODE_TRANSLATE, '1);
    send_request(mlptw_pkg::MODE_TRANSLATE, random_address());
  endtask

  task automatic test_allocate_and_translate();
    logic [VA_W-1:0] mid_branch;
    mid_branch = VA_W'(1) << (OFFSET_BITS + IDX_BITS);
    send_request(mlptw_pkg::MODE_ALLOCATE, '0);
    send_request(mlptw_pkg::MODE_TRANSLATE, VA_W'((1 << OFFSET_BITS) - 1));
    send_request(mlptw_pkg::MODE_TRANSLATE, mid_branch);
    send_request(mlptw_pkg::MODE_ALLOCATE, mid_branch | VA_W'(12'h5a5));
    send_request(mlptw_pkg::MODE_TRANSLATE, mid_branch | VA_W'(12'h0ff));
    send_request(mlptw_pkg::MODE_ALLOCATE, VA_W'(12'h123));
    send_request(mlptw_pkg::MODE_TRANSLATE, VA_W'(1) << (OFFSET_BITS + 3 * IDX_BITS));
  endtask

  task automatic test_index_extremes();
    send_request(mlptw_pkg::MODE_TRANSLATE, '1);
    send_request(mlptw_pkg::MODE_ALLOCATE, '1);
    send_request(mlptw_pkg::MODE_TRANSLATE, '1);
    send_request(mlptw_pkg::MODE_TRANSLATE,
                 {VA_W{1'b1}} ^ VA_W'((1 << OFFSET_BITS) - 1));
    send_request(mlptw_pkg::MODE_TRANSLATE, {VA_W{1'b1}} ^ (VA_W'(1) << OFFSET_BITS));
    send_request(mlptw_pkg::MODE_ALLOCATE, VA_W'(48'h5555_5555_5555));
    send_request(mlptw_pkg::MODE_TRANSLATE, VA_W'(48'haaaa_aaaa_aaaa));
    send_request(mlptw_pkg::MODE_TRANSLATE, VA_W'(48'h5555_5555_5000));
  endtask

  // Mostly clustered addresses; the rest random addresses, mainly translates
  task automatic test_random_mix();
    int unsigned pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) idling_on = $urandom_range(0, 2) != 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) send_request(mlptw_pkg::MODE_TRANSLATE, clustered_address());
      else if (pick < 85) send_request(mlptw_pkg::MODE_ALLOCATE, clustered_address());
      else if (pick < 97) send_request(mlptw_pkg::MODE_TRANSLATE, random_address());
      else send_request(mlptw_pkg::MODE_ALLOCATE, random_address());
      maybe_idle();
    end
    idling_on = 1'b0;
  endtask

  // Allocate fresh paths until the pages are gone, then look past the end
  task automatic test_page_exhaustion();
    int guard;
    guard = 0;
    while (next_free_page < PHYS_PAGES && guard < 200) begin
      send_request(mlptw_pkg::MODE_ALLOCATE, random_address());
      guard++;
    end
    repeat (4) send_request(mlptw_pkg::MODE_ALLOCATE, random_address());
    send_request(mlptw_pkg::MODE_ALLOCATE, '1);
    send_request(mlptw_pkg::MODE_TRANSLATE, '1);
    repeat (4) send_request(mlptw_pkg::MODE_TRANSLATE, clustered_address());
  endtask

  // Compare each result transfer with the oldest expectation
  always @(negedge clk) begin
    mlptw_pkg::result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: %p", result);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.mapped_address !== want.mapped_address) begin
          $error("mapped_address: expected %0h, got %0h",
                 want.mapped_address, result.mapped_address);
          fail_count++;
        end
        if (result.fault !== want.fault) begin
          $error("fault: expected %0b, got %0b", want.fault, result.fault);
          fail_count++;
        end
        if (result.out_of_memory !== want.out_of_memory) begin
          $error("out_of_memory: expected %0b, got %0b",
                 want.out_of_memory, result.out_of_memory);
          fail_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) table_image[i] = '0;
    root_page = 0;
    root_valid = 1'b0;
    next_free_page = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_translate_without_root();
    test_allocate_and_translate();
    test_index_extremes();
    test_random_mix();
    test_page_exhaustion();

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LEVEL_COUNT + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit: clearing pass plus every request at its slowest, many times over
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
design/mlptw_pkg.sv
design/multilevel_page_table_walker.sv
dv/multilevel_page_table_walker_tb.sv
